/* rtl/core/isbs_pkg.sv */
package isbs_pkg;

  localparam int unsigned SampleW            = 8;
  localparam int unsigned CountW             = 9;
  localparam int unsigned CountReset         = 256;
  localparam int unsigned MaxStationsDefault = 256;
  localparam int unsigned TotalW             = 25;
  localparam int unsigned CircW              = 26;
  localparam int unsigned FracBits           = 8;
  localparam int unsigned PowTermW           = 17;
  localparam int unsigned CrossTermW         = 17;
  localparam int unsigned PowTermMax         = 65536;
  localparam int unsigned CrossTermMax       = 32768;

  typedef enum logic [1:0] {
    StAccum,
    StDivide,
    StLoad
  } isbs_state_e;

  typedef struct packed {
    logic accumulate;
    logic close_sum;
    logic div_step;
    logic load_out;
  } isbs_cmd_t;

  typedef struct packed {
    logic last_item;
    logic out_free;
  } isbs_status_t;

  function automatic int unsigned pow_width(int unsigned max_stations);
    return $clog2(PowTermMax * max_stations + 1);
  endfunction

  function automatic int unsigned cross_mag_width(int unsigned max_stations);
    return $clog2(CrossTermMax * max_stations + 1);
  endfunction

  function automatic int unsigned div_width(int unsigned max_stations);
    int unsigned pw;
    int unsigned cw;
    pw = pow_width(max_stations) + FracBits;
    cw = cross_mag_width(max_stations) + FracBits + 1;
    return (pw > cw) ? pw : cw;
  endfunction

endpackage

/* rtl/core/isbs_sample_if.sv */
interface isbs_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [isbs_pkg::SampleW-1:0]   pol_a_real;
  logic signed [isbs_pkg::SampleW-1:0]   pol_a_imag;
  logic signed [isbs_pkg::SampleW-1:0]   pol_b_real;
  logic signed [isbs_pkg::SampleW-1:0]   pol_b_imag;

  modport source (
    output valid, pol_a_real, pol_a_imag, pol_b_real, pol_b_imag,
    input  ready
  );

  modport sink (
    input  valid, pol_a_real, pol_a_imag, pol_b_real, pol_b_imag,
    output ready
  );
endinterface

/* rtl/core/isbs_stokes_if.sv */
interface isbs_stokes_if;
  logic                               valid;
  logic                               ready;
  logic        [isbs_pkg::TotalW-1:0] stokes_total;
  logic signed [isbs_pkg::CircW-1:0]  stokes_circular;

  modport source (
    output valid, stokes_total, stokes_circular,
    input  ready
  );

  modport sink (
    input  valid, stokes_total, stokes_circular,
    output ready
  );
endinterface

/* rtl/core/isbs_ctrl.sv */
module isbs_ctrl #(
  parameter int unsigned DivSteps = isbs_pkg::div_width(isbs_pkg::MaxStationsDefault)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  isbs_pkg::isbs_status_t status_i,
  output isbs_pkg::isbs_cmd_t    cmd_o
);

  localparam int unsigned CntW = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  isbs_pkg::isbs_state_e state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  take;

  assign take = in_valid_i && (state_q == isbs_pkg::StAccum);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      isbs_pkg::StAccum: begin
        if (take && status_i.last_item) begin
          state_d = isbs_pkg::StDivide;
          cnt_d   = CntW'(DivSteps - 1);
        end
      end
      isbs_pkg::StDivide: begin
        if (cnt_q == '0) begin
          state_d = isbs_pkg::StLoad;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      isbs_pkg::StLoad: begin
        if (status_i.out_free) begin
          state_d = isbs_pkg::StAccum;
        end
      end
      default: state_d = isbs_pkg::StAccum;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      isbs_pkg::StAccum: begin
        in_ready_o       = 1'b1;
        cmd_o.accumulate = take;
        cmd_o.close_sum  = take && status_i.last_item;
      end
      isbs_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
      end
      isbs_pkg::StLoad: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isbs_pkg::StAccum;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* rtl/core/isbs_datapath.sv */
module isbs_datapath #(
  parameter int unsigned MaxStations = isbs_pkg::MaxStationsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [isbs_pkg::CountW-1:0]  cfg_wdata_i,
  input  isbs_pkg::isbs_cmd_t                 cmd_i,
  output isbs_pkg::isbs_status_t              status_o,
  input  logic signed [isbs_pkg::SampleW-1:0] pol_a_real_i,
  input  logic signed [isbs_pkg::SampleW-1:0] pol_a_imag_i,
  input  logic signed [isbs_pkg::SampleW-1:0] pol_b_real_i,
  input  logic signed [isbs_pkg::SampleW-1:0] pol_b_imag_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic        [isbs_pkg::TotalW-1:0]  stokes_total_o,
  output logic signed [isbs_pkg::CircW-1:0]   stokes_circular_o
);

  localparam int unsigned PowW      = isbs_pkg::pow_width(MaxStations);
  localparam int unsigned CrossMagW = isbs_pkg::cross_mag_width(MaxStations);
  localparam int unsigned CrossW    = CrossMagW + 1;
  localparam int unsigned DivW      = isbs_pkg::div_width(MaxStations);
  localparam int unsigned IdxW      = $clog2(MaxStations + 1);
  localparam int unsigned NW        = (isbs_pkg::CountW > IdxW) ? isbs_pkg::CountW : IdxW;
  localparam int unsigned PTW       = isbs_pkg::PowTermW;
  localparam int unsigned CTW       = isbs_pkg::CrossTermW;

  logic        [isbs_pkg::CountW-1:0] count_q;
  logic        [PowW-1:0]             pow_q;
  logic signed [CrossW-1:0]           cross_q;
  logic        [IdxW-1:0]             idx_q;
  logic        [IdxW-1:0]             idx_next;
  logic        [NW-1:0]               n_act;
  logic        [NW-1:0]               div_n_q;

  logic signed [PTW:0]                sq_ar, sq_ai, sq_br, sq_bi;
  logic signed [PTW:0]                pow_sum_s;
  logic        [PTW-1:0]              pow_term;
  logic signed [CTW-1:0]              x_arbi, x_aibr;
  logic signed [CTW-1:0]              cross_term;
  logic        [PowW-1:0]             pow_sum;
  logic signed [CrossW-1:0]           cross_sum;
  logic        [CrossW-1:0]           cross_mag;

  logic        [DivW-1:0]             dvd_p_q, dvd_c_q;
  logic        [NW:0]                 rem_p_q, rem_c_q;
  logic                               neg_q;
  logic        [NW:0]                 rem_p_sh, rem_c_sh;
  logic                               qb_p, qb_c;

  logic                               out_valid_q;
  logic        [isbs_pkg::TotalW-1:0] total_q;
  logic signed [isbs_pkg::CircW-1:0]  circ_q;
  logic        [isbs_pkg::CircW-1:0]  circ_mag;

  always_comb begin
    if (count_q == '0) begin
      n_act = NW'(1);
    end else if (NW'(count_q) > NW'(MaxStations)) begin
      n_act = NW'(MaxStations);
    end else begin
      n_act = NW'(count_q);
    end
  end

  assign idx_next           = idx_q + 1'b1;
  assign status_o.last_item = NW'(idx_next) >= n_act;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign sq_ar      = (PTW+1)'(pol_a_real_i * pol_a_real_i);
  assign sq_ai      = (PTW+1)'(pol_a_imag_i * pol_a_imag_i);
  assign sq_br      = (PTW+1)'(pol_b_real_i * pol_b_real_i);
  assign sq_bi      = (PTW+1)'(pol_b_imag_i * pol_b_imag_i);
  assign pow_sum_s  = sq_ar + sq_ai + sq_br + sq_bi;
  assign pow_term   = pow_sum_s[PTW-1:0];
  assign x_arbi     = CTW'(pol_a_real_i * pol_b_imag_i);
  assign x_aibr     = CTW'(pol_a_imag_i * pol_b_real_i);
  assign cross_term = x_arbi - x_aibr;

  assign pow_sum   = pow_q + PowW'(pow_term);
  assign cross_sum = cross_q + CrossW'(cross_term);
  assign cross_mag = cross_sum[CrossW-1] ? CrossW'(-cross_sum) : CrossW'(cross_sum);

  assign rem_p_sh = {rem_p_q[NW-1:0], dvd_p_q[DivW-1]};
  assign rem_c_sh = {rem_c_q[NW-1:0], dvd_c_q[DivW-1]};
  assign qb_p     = rem_p_sh >= {1'b0, div_n_q};
  assign qb_c     = rem_c_sh >= {1'b0, div_n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= isbs_pkg::CountW'(isbs_pkg::CountReset);
      pow_q   <= '0;
      cross_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (cmd_i.close_sum) begin
        pow_q   <= '0;
        cross_q <= '0;
        idx_q   <= '0;
      end else if (cmd_i.accumulate) begin
        pow_q   <= pow_sum;
        cross_q <= cross_sum;
        idx_q   <= idx_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close_sum) begin
      dvd_p_q <= DivW'(pow_sum) << isbs_pkg::FracBits;
      dvd_c_q <= DivW'(cross_mag[CrossMagW-1:0]) << (isbs_pkg::FracBits + 1);
      rem_p_q <= '0;
      rem_c_q <= '0;
      neg_q   <= cross_sum[CrossW-1];
      div_n_q <= n_act;
    end else if (cmd_i.div_step) begin
      dvd_p_q <= {dvd_p_q[DivW-2:0], qb_p};
      dvd_c_q <= {dvd_c_q[DivW-2:0], qb_c};
      rem_p_q <= qb_p ? rem_p_sh - {1'b0, div_n_q} : rem_p_sh;
      rem_c_q <= qb_c ? rem_c_sh - {1'b0, div_n_q} : rem_c_sh;
    end
  end

  assign circ_mag = dvd_c_q[isbs_pkg::CircW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      total_q <= dvd_p_q[isbs_pkg::TotalW-1:0];
      circ_q  <= neg_q ? $signed(-circ_mag) : $signed(circ_mag);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign stokes_total_o    = total_q;
  assign stokes_circular_o = circ_q;

endmodule

/* rtl/core/incoherent_stokes_beam_sum_unit.sv */
// Incoherent Stokes I/V beam sum.
// sample_i carries one station's dual-polarization 8-bit complex word per
// handshake, stations in order within one time and channel slot. stokes_o
// carries one word per completed sum: Stokes I and Stokes V, fixed point with
// 8 fraction bits, truncated toward zero. cfg_we_i/cfg_wdata_i set the
// station count N (0 acts as 1, values above MaxStations saturate); write it
// only while the block is idle.
// Each non-final station word is accepted in the same cycle it is offered. The
// final word of a sum starts a restoring divider that retires one quotient bit
// per cycle; the input stalls through the divide state and then the load state,
// so no word of the next sum is taken until the result is loaded into the
// output register that drives stokes_o.
// A result waits in the output register while the receiver stalls; the next
// sum accumulates meanwhile and holds in its load cycle until the register
// frees. Reset clears the sums, the station index and the output valid, and
// sets N to 256.
module incoherent_stokes_beam_sum_unit #(
  parameter int unsigned MaxStations = isbs_pkg::MaxStationsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [isbs_pkg::CountW-1:0]   cfg_wdata_i,
  isbs_sample_if.sink                   sample_i,
  isbs_stokes_if.source                 stokes_o
);

  isbs_pkg::isbs_cmd_t    cmd;
  isbs_pkg::isbs_status_t status;

  isbs_ctrl #(
    .DivSteps (isbs_pkg::div_width(MaxStations))
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  isbs_datapath #(
    .MaxStations (MaxStations)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .pol_a_real_i      (sample_i.pol_a_real),
    .pol_a_imag_i      (sample_i.pol_a_imag),
    .pol_b_real_i      (sample_i.pol_b_real),
    .pol_b_imag_i      (sample_i.pol_b_imag),
    .out_ready_i       (stokes_o.ready),
    .out_valid_o       (stokes_o.valid),
    .stokes_total_o    (stokes_o.stokes_total),
    .stokes_circular_o (stokes_o.stokes_circular)
  );

endmodule

/* tb/sv/tb_incoherent_stokes_beam_sum_unit.sv */
module tb_incoherent_stokes_beam_sum_unit;

  localparam int RandomWords = 2000;
  localparam int DrainCycles = 40;
  localparam int StallLimit  = 4000;
  localparam int NumDirected = 20;
  localparam int MaxPrinted  = 50;

  typedef struct packed {
    logic signed [isbs_pkg::SampleW-1:0] a_re;
    logic signed [isbs_pkg::SampleW-1:0] a_im;
    logic signed [isbs_pkg::SampleW-1:0] b_re;
    logic signed [isbs_pkg::SampleW-1:0] b_im;
  } station_word_t;

  typedef struct packed {
    logic        [isbs_pkg::TotalW-1:0] total;
    logic signed [isbs_pkg::CircW-1:0]  circ;
  } stokes_word_t;

  typedef enum logic {
    RowWrite,
    RowSample
  } row_kind_e;

  typedef struct packed {
    row_kind_e                           kind;
    logic        [isbs_pkg::CountW-1:0]  count;
    logic signed [isbs_pkg::SampleW-1:0] a_re;
    logic signed [isbs_pkg::SampleW-1:0] a_im;
    logic signed [isbs_pkg::SampleW-1:0] b_re;
    logic signed [isbs_pkg::SampleW-1:0] b_im;
    logic                                has_exp;
    logic        [isbs_pkg::TotalW-1:0]  total;
    logic signed [isbs_pkg::CircW-1:0]   circ;
  } directed_row_t;

  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{RowWrite,  1,    0,    0,    0,    0, 0,        0,        0},
    '{RowSample, 0,    0,    0,    0,    0, 1,        0,        0},
    '{RowSample, 0, -128, -128, -128, -128, 1, 16777216,        0},
    '{RowSample, 0, -128,    0,    0, -128, 1,  8388608,  8388608},
    '{RowSample, 0,    0, -128, -128,    0, 1,  8388608, -8388608},
    '{RowSample, 0, -128, -128,  127, -128, 1, 16711936, 16711680},
    '{RowSample, 0,  127,  127,  127,  127, 1, 16516096,        0},
    '{RowWrite,  0,    0,    0,    0,    0, 0,        0,        0},
    '{RowSample, 0,    1,    2,    3,    4, 1,     7680,    -1024},
    '{RowWrite,  3,    0,    0,    0,    0, 0,        0,        0},
    '{RowSample, 0,    1,    0,    0,    1, 0,        0,        0},
    '{RowSample, 0,    0,    0,    0,    0, 0,        0,        0},
    '{RowSample, 0,    0,    0,    0,    0, 1,      170,      170},
    '{RowSample, 0,    0,    1,    1,    0, 0,        0,        0},
    '{RowSample, 0,    0,    0,    0,    0, 0,        0,        0},
    '{RowSample, 0,    0,    0,    0,    0, 1,      170,     -170},
    '{RowWrite,  2,    0,    0,    0,    0, 0,        0,        0},
    '{RowSample, 0,    2,    0,    0,    0, 0,        0,        0},
    '{RowWrite,  1,    0,    0,    0,    0, 0,        0,        0},
    '{RowSample, 0,    0,    0,    3,    0, 1,     3328,        0}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we;
  logic [isbs_pkg::CountW-1:0] cfg_wdata;

  isbs_sample_if sample_bus ();
  isbs_stokes_if stokes_bus ();

  incoherent_stokes_beam_sum_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_bus),
    .stokes_o    (stokes_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [isbs_pkg::CountW-1:0] station_count;
  longint                      power_sum;
  longint                      cross_sum;
  int                          stations_taken;
  stokes_word_t                stokes_expected_q [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int words_sent;
  int results_seen;
  int count_writes;
  int mismatches;
  int quiet_cycles;

  function automatic int eff_count(input logic [isbs_pkg::CountW-1:0] c);
    if (c == 0) return 1;
    if (c > isbs_pkg::MaxStationsDefault) return int'(isbs_pkg::MaxStationsDefault);
    return int'(c);
  endfunction

  function automatic bit accumulate_station(input station_word_t w, output stokes_word_t res);
    int     ar;
    int     ai;
    int     br;
    int     bi;
    int     n;
    longint quot;
    longint mag;
    ar = w.a_re;
    ai = w.a_im;
    br = w.b_re;
    bi = w.b_im;
    power_sum += ar * ar + ai * ai + br * br + bi * bi;
    cross_sum += ar * bi - ai * br;
    stations_taken++;
    n = eff_count(station_count);
    res = '0;
    if (stations_taken < n) return 1'b0;
    quot = (power_sum * 256) / n;
    mag  = ((cross_sum < 0) ? -cross_sum : cross_sum) * 512 / n;
    if (cross_sum < 0) mag = -mag;
    res.total = quot[isbs_pkg::TotalW-1:0];
    res.circ  = mag[isbs_pkg::CircW-1:0];
    power_sum      = 0;
    cross_sum      = 0;
    stations_taken = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic write_station_count(input logic [isbs_pkg::CountW-1:0] value);
    sample_bus.valid = 1'b0;
    while (stokes_expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we        = 1'b0;
    station_count = value;
    count_writes++;
  endtask

  task automatic send_station_word(input station_word_t w, input bit typed,
                                   input stokes_word_t typed_exp);
    stokes_word_t pred;
    stokes_word_t exp_word;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      sample_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    sample_bus.valid      = 1'b1;
    sample_bus.pol_a_real = w.a_re;
    sample_bus.pol_a_imag = w.a_im;
    sample_bus.pol_b_real = w.b_re;
    sample_bus.pol_b_imag = w.b_im;
    do @(posedge clk_i); while (!sample_bus.ready);
    words_sent++;
    if (accumulate_station(w, pred)) begin
      exp_word          = typed ? typed_exp : pred;
      stokes_expected_q = {stokes_expected_q, exp_word};
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) stokes_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    stokes_word_t e;
    if (rst_ni && stokes_bus.valid && stokes_bus.ready) begin
      results_seen++;
      if (stokes_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word I=%0d V=%0d",
                                  stokes_bus.stokes_total, stokes_bus.stokes_circular));
      end else begin
        e = stokes_expected_q.pop_front();
        if (stokes_bus.stokes_total !== e.total)
          report_mismatch($sformatf("stokes_total got %0d expected %0d",
                                    stokes_bus.stokes_total, e.total));
        if (stokes_bus.stokes_circular !== e.circ)
          report_mismatch($sformatf("stokes_circular got %0d expected %0d",
                                    stokes_bus.stokes_circular, e.circ));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_bus.valid && sample_bus.ready) || (stokes_bus.valid && stokes_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("watchdog: no handshake for %0d cycles", StallLimit);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    station_word_t               w;
    stokes_word_t                typed_exp;
    directed_row_t               row;
    logic [isbs_pkg::SampleW-1:0] f [4];
    logic [isbs_pkg::CountW-1:0]  cnt;
    int                          n_eff;
    int                          n_words;
    int                          pick;
    int                          phase;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    sample_bus.valid      = 1'b0;
    sample_bus.pol_a_real = '0;
    sample_bus.pol_a_imag = '0;
    sample_bus.pol_b_real = '0;
    sample_bus.pol_b_imag = '0;
    stokes_bus.ready      = 1'b0;
    station_count         = isbs_pkg::CountW'(isbs_pkg::CountReset);
    power_sum             = 0;
    cross_sum             = 0;
    stations_taken        = 0;
    words_sent            = 0;
    results_seen          = 0;
    count_writes          = 0;
    mismatches            = 0;
    quiet_cycles          = 0;
    snd_idle_pct          = 34;
    rcv_idle_pct          = 54;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NumDirected; r++) begin
      row = DirectedRows[r];
      if (row.kind == RowWrite) begin
        write_station_count(row.count);
      end else begin
        w         = '{row.a_re, row.a_im, row.b_re, row.b_im};
        typed_exp = '{row.total, row.circ};
        send_station_word(w, row.has_exp, typed_exp);
      end
    end

    phase = 0;
    while (words_sent < RandomWords) begin
      if (words_sent >= 2 * RandomWords / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else if (words_sent >= RandomWords / 3) begin
        snd_idle_pct = 54;
        rcv_idle_pct = 34;
      end
      pick = $urandom_range(0, 39);
      if (phase == 0 || pick == 0) cnt = isbs_pkg::CountW'(511);
      else if (phase == 1 || pick == 1) cnt = '0;
      else if (pick == 2) cnt = isbs_pkg::CountW'(isbs_pkg::MaxStationsDefault);
      else if (pick == 3) cnt = isbs_pkg::CountW'($urandom_range(17, 511));
      else cnt = isbs_pkg::CountW'($urandom_range(1, 16));
      phase++;
      write_station_count(cnt);
      n_eff   = eff_count(cnt);
      n_words = n_eff * ((n_eff > 16) ? 1 : $urandom_range(1, 3));
      if (n_eff > 1 && $urandom_range(0, 3) == 0) n_words += $urandom_range(1, n_eff - 1);
      repeat (n_words) begin
        for (int k = 0; k < 4; k++) begin
          pick = $urandom_range(0, 7);
          f[k] = (pick == 0) ? 8'h80 : (pick == 1) ? 8'h7f : 8'($urandom_range(0, 255));
        end
        w = '{f[0], f[1], f[2], f[3]};
        send_station_word(w, 1'b0, '0);
      end
    end

    sample_bus.valid = 1'b0;
    while (stokes_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d station words over %0d count settings", words_sent, count_writes);
    $display("%0d Stokes words checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/isbs_pkg.sv
rtl/core/isbs_sample_if.sv
rtl/core/isbs_stokes_if.sv
rtl/core/isbs_ctrl.sv
rtl/core/isbs_datapath.sv
rtl/core/incoherent_stokes_beam_sum_unit.sv
tb/sv/tb_incoherent_stokes_beam_sum_unit.sv
